// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file dms_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define DMS_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define DMS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/dms_pkg.sv =====
package dms_pkg;

  localparam int READY_DEPTH = 16;
  localparam int DELAY_SLOTS = 16;

  localparam int FIFO_W  = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int SLOT_W  = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;
  localparam int FILL_W  = $clog2(READY_DEPTH + 1);
  localparam int SCNT_W  = $clog2(DELAY_SLOTS + 1);
  localparam int WALK_W  = (FILL_W > SCNT_W) ? FILL_W : SCNT_W;

  typedef enum logic [1:0] {
    CMD_SEND   = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_FETCH  = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEND_FIND,
    S_TICK_WALK,
    S_CAN_SLOT,
    S_CAN_FIFO,
    S_FETCH_RD,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [7:0]  task_ref;
    logic [15:0] kind;
    logic [31:0] payload;
  } entry_t;

  typedef struct packed {
    entry_t      msg;
    logic [15:0] countdown;
  } slot_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam int SLOTW_W = $bits(slot_t);

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic send_find;
    logic walk_init;
    logic walk_tick;
    logic walk_can_slot;
    logic walk_can_fifo;
    logic fetch_rd;
    logic fetch_out;
  } dms_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    cmd_t cmd;
    logic task_zero;
    logic delay_zero;
    logic fifo_empty;
    logic find_done;
    logic walk_done;
  } dms_stat_t;

endpackage

// ===== rtl/core/dms_ram.sv =====
module dms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/dms_ctrl.sv =====
module dms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  dms_pkg::dms_stat_t  stat,
  output dms_pkg::dms_cmd_t   cmd
);

  dms_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dms_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != dms_pkg::S_IDLE);
  assign out_valid = (state_r == dms_pkg::S_RESULT);

  // Next state and commands to the datapath.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      dms_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = dms_pkg::S_DECODE;
        end
      end
      dms_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        case (stat.cmd)
          dms_pkg::CMD_SEND: begin
            if (stat.task_zero || stat.delay_zero) begin
              state_nxt = dms_pkg::S_RESULT;
            end else begin
              cmd.walk_init = 1'b1;
              state_nxt     = dms_pkg::S_SEND_FIND;
            end
          end
          dms_pkg::CMD_TICK: begin
            cmd.walk_init = 1'b1;
            state_nxt     = dms_pkg::S_TICK_WALK;
          end
          dms_pkg::CMD_FETCH: begin
            if (stat.fifo_empty) begin
              state_nxt = dms_pkg::S_RESULT;
            end else begin
              cmd.fetch_rd = 1'b1;
              state_nxt    = dms_pkg::S_FETCH_RD;
            end
          end
          dms_pkg::CMD_CANCEL: begin
            if (stat.task_zero) begin
              state_nxt = dms_pkg::S_RESULT;
            end else begin
              cmd.walk_init = 1'b1;
              state_nxt     = dms_pkg::S_CAN_SLOT;
            end
          end
          default: state_nxt = dms_pkg::S_RESULT;
        endcase
      end
      dms_pkg::S_SEND_FIND: begin
        cmd.send_find = 1'b1;
        if (stat.find_done) begin
          state_nxt = dms_pkg::S_RESULT;
        end
      end
      dms_pkg::S_TICK_WALK: begin
        cmd.walk_tick = 1'b1;
        if (stat.walk_done) begin
          state_nxt = dms_pkg::S_RESULT;
        end
      end
      dms_pkg::S_CAN_SLOT: begin
        cmd.walk_can_slot = 1'b1;
        if (stat.walk_done) begin
          cmd.walk_init = 1'b1;
          state_nxt     = dms_pkg::S_CAN_FIFO;
        end
      end
      dms_pkg::S_CAN_FIFO: begin
        cmd.walk_can_fifo = 1'b1;
        if (stat.walk_done) begin
          state_nxt = dms_pkg::S_RESULT;
        end
      end
      dms_pkg::S_FETCH_RD: begin
        cmd.fetch_out = 1'b1;
        state_nxt     = dms_pkg::S_RESULT;
      end
      dms_pkg::S_RESULT: begin
        if (!out_stall) begin
          state_nxt = dms_pkg::S_IDLE;
        end
      end
      default: state_nxt = dms_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/dms_dp.sv =====
module dms_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  dms_pkg::dms_cmd_t   cmd,
  output dms_pkg::dms_stat_t  stat,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_task_ref,
  input  logic [15:0]         in_msg_kind,
  input  logic [31:0]         in_payload_handle,
  input  logic [15:0]         in_delay_ticks,
  output logic [1:0]          out_status,
  output logic                out_delivered,
  output logic [7:0]          out_task,
  output logic [15:0]         out_kind,
  output logic [31:0]         out_payload,
  output logic [5:0]          out_count,
  output logic [4:0]          out_dropped
);

  // Latched request.
  dms_pkg::cmd_t            cmd_r;
  dms_pkg::entry_t          msg_r;
  logic [15:0]              delay_r;

  // FIFO control and slot occupancy.
  logic [dms_pkg::FIFO_W-1:0] rptr_r, rptr_nxt;
  logic [dms_pkg::FIFO_W-1:0] wptr_r, wptr_nxt;
  logic [dms_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [dms_pkg::DELAY_SLOTS-1:0] busy_r, busy_nxt;

  // Walk pipeline: issue index, then process it in the following cycle.
  logic [dms_pkg::WALK_W-1:0] idx_r, idx_nxt;
  logic                       pval_r, pval_nxt;
  logic [dms_pkg::SLOT_W-1:0] pidx_r, pidx_nxt;
  logic [dms_pkg::FIFO_W-1:0] scan_r, scan_nxt;
  logic [dms_pkg::FIFO_W-1:0] paddr_r, paddr_nxt;

  // Result register.
  dms_pkg::status_t status_r, status_nxt;
  logic             deliv_r, deliv_nxt;
  dms_pkg::entry_t  res_r, res_nxt;
  logic [5:0]       count_r, count_nxt;
  logic [4:0]       drop_r, drop_nxt;

  // RAM ports.
  logic                       f_we, s_we;
  logic [dms_pkg::FIFO_W-1:0] f_waddr, f_raddr;
  logic [dms_pkg::SLOT_W-1:0] s_waddr, s_raddr;
  dms_pkg::entry_t            f_wdata, f_rdata;
  dms_pkg::slot_t             s_wdata, s_rdata;

  logic [dms_pkg::WALK_W-1:0] limit;
  logic                       fifo_full;
  logic                       idx_busy;
  logic                       in_range;

  function automatic logic [dms_pkg::FIFO_W-1:0] ptr_inc(
    input logic [dms_pkg::FIFO_W-1:0] p
  );
    if (p == dms_pkg::FIFO_W'(dms_pkg::READY_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  dms_ram #(.WIDTH(dms_pkg::ENTRY_W), .DEPTH(dms_pkg::READY_DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  dms_ram #(.WIDTH(dms_pkg::SLOTW_W), .DEPTH(dms_pkg::DELAY_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign fifo_full = (fill_r == dms_pkg::FILL_W'(dms_pkg::READY_DEPTH));
  assign limit     = cmd.walk_can_fifo ? dms_pkg::WALK_W'(fill_r)
                                       : dms_pkg::WALK_W'(dms_pkg::DELAY_SLOTS);
  assign in_range  = (idx_r < dms_pkg::WALK_W'(dms_pkg::DELAY_SLOTS));
  assign idx_busy  = busy_r[idx_r[dms_pkg::SLOT_W-1:0]];

  assign stat.cmd        = cmd_r;
  assign stat.task_zero  = (msg_r.task_ref == 8'd0);
  assign stat.delay_zero = (delay_r == 16'd0);
  assign stat.fifo_empty = (fill_r == '0);
  assign stat.find_done  = !in_range || !idx_busy;
  assign stat.walk_done  = (idx_r == limit) && !pval_r;

  assign f_raddr = cmd.fetch_rd ? rptr_r : scan_r;
  assign s_raddr = idx_r[dms_pkg::SLOT_W-1:0];

  // Request execution.
  always_comb begin
    rptr_nxt   = rptr_r;
    wptr_nxt   = wptr_r;
    fill_nxt   = fill_r;
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    pval_nxt   = 1'b0;
    pidx_nxt   = pidx_r;
    scan_nxt   = scan_r;
    paddr_nxt  = paddr_r;
    status_nxt = status_r;
    deliv_nxt  = deliv_r;
    res_nxt    = res_r;
    count_nxt  = count_r;
    drop_nxt   = drop_r;
    f_we       = 1'b0;
    f_waddr    = wptr_r;
    f_wdata    = msg_r;
    s_we       = 1'b0;
    s_waddr    = idx_r[dms_pkg::SLOT_W-1:0];
    s_wdata    = '{msg: msg_r, countdown: delay_r};

    if (cmd.load) begin
      status_nxt = dms_pkg::ST_OK;
      deliv_nxt  = 1'b0;
      res_nxt    = '0;
      count_nxt  = '0;
      drop_nxt   = '0;
    end

    // First decision on the request.
    if (cmd.decode) begin
      if (cmd_r == dms_pkg::CMD_SEND) begin
        if (msg_r.task_ref == 8'd0) begin
          status_nxt = dms_pkg::ST_BAD;
        end else if (delay_r == 16'd0) begin
          if (fifo_full) begin
            status_nxt = dms_pkg::ST_FULL;
          end else begin
            f_we     = 1'b1;
            wptr_nxt = ptr_inc(wptr_r);
            fill_nxt = fill_r + 1'b1;
          end
        end
      end else if (cmd_r == dms_pkg::CMD_FETCH && fill_r == '0) begin
        status_nxt = dms_pkg::ST_NONE;
      end
    end

    if (cmd.walk_init) begin
      idx_nxt  = '0;
      scan_nxt = rptr_r;
    end

    // Lowest free slot, one slot per cycle.
    if (cmd.send_find) begin
      if (!in_range) begin
        status_nxt = dms_pkg::ST_FULL;
      end else if (!idx_busy) begin
        s_we = 1'b1;
        busy_nxt[idx_r[dms_pkg::SLOT_W-1:0]] = 1'b1;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end

    // Issue stage of the walks.
    if ((cmd.walk_tick || cmd.walk_can_slot || cmd.walk_can_fifo) && !cmd.walk_init &&
        idx_r != limit) begin
      idx_nxt   = idx_r + 1'b1;
      pval_nxt  = 1'b1;
      pidx_nxt  = idx_r[dms_pkg::SLOT_W-1:0];
      paddr_nxt = scan_r;
      scan_nxt  = ptr_inc(scan_r);
    end

    // Tick: count down, or release an expired slot into the FIFO (dropped when the FIFO is full).
    if (cmd.walk_tick && pval_r && busy_r[pidx_r]) begin
      if (s_rdata.countdown != 16'd0) begin
        s_we    = 1'b1;
        s_waddr = pidx_r;
        s_wdata = '{msg: s_rdata.msg, countdown: s_rdata.countdown - 1'b1};
      end else begin
        busy_nxt[pidx_r] = 1'b0;
        if (!fifo_full) begin
          f_we     = 1'b1;
          f_wdata  = s_rdata.msg;
          wptr_nxt = ptr_inc(wptr_r);
          fill_nxt = fill_r + 1'b1;
          if (count_r != 6'd63) begin
            count_nxt = count_r + 1'b1;
          end
        end else if (drop_r != 5'd31) begin
          drop_nxt = drop_r + 1'b1;
        end
      end
    end

    // Cancel in the slot pool.
    if (cmd.walk_can_slot && pval_r && busy_r[pidx_r] &&
        s_rdata.msg.task_ref == msg_r.task_ref && s_rdata.msg.kind == msg_r.kind) begin
      busy_nxt[pidx_r] = 1'b0;
      if (count_r != 6'd63) begin
        count_nxt = count_r + 1'b1;
      end
    end

    // Cancel in the FIFO: matching entries are zeroed in place.
    if (cmd.walk_can_fifo && pval_r &&
        f_rdata.task_ref == msg_r.task_ref && f_rdata.kind == msg_r.kind) begin
      f_we    = 1'b1;
      f_waddr = paddr_r;
      f_wdata = '0;
      if (count_r != 6'd63) begin
        count_nxt = count_r + 1'b1;
      end
    end

    // Pop of the head entry.
    if (cmd.fetch_out) begin
      res_nxt   = f_rdata;
      deliv_nxt = (f_rdata.task_ref != 8'd0) && (f_rdata.kind != 16'd0);
      rptr_nxt  = ptr_inc(rptr_r);
      fill_nxt  = fill_r - 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r <= '0;
      wptr_r <= '0;
      fill_r <= '0;
      busy_r <= '0;
      pval_r <= 1'b0;
    end else begin
      rptr_r <= rptr_nxt;
      wptr_r <= wptr_nxt;
      fill_r <= fill_nxt;
      busy_r <= busy_nxt;
      pval_r <= pval_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= dms_pkg::cmd_t'(in_command);
      msg_r   <= '{task_ref: in_task_ref, kind: in_msg_kind, payload: in_payload_handle};
      delay_r <= in_delay_ticks;
    end
    idx_r    <= idx_nxt;
    pidx_r   <= pidx_nxt;
    scan_r   <= scan_nxt;
    paddr_r  <= paddr_nxt;
    status_r <= status_nxt;
    deliv_r  <= deliv_nxt;
    res_r    <= res_nxt;
    count_r  <= count_nxt;
    drop_r   <= drop_nxt;
  end

  assign out_status    = status_r;
  assign out_delivered = deliv_r;
  assign out_task      = res_r.task_ref;
  assign out_kind      = res_r.kind;
  assign out_payload   = res_r.payload;
  assign out_count     = count_r;
  assign out_dropped   = drop_r;

endmodule

// ===== rtl/core/delayed_message_scheduler.sv =====
// Message scheduler with a 16-entry ready FIFO and 16 delay slots. One request is
// handled at a time and answered with exactly one result; a new request is taken
// once that result has been accepted. Walks through the slot and FIFO memories
// visit one entry per cycle. Fetch reads the FIFO head unless the FIFO is empty;
// send writes the FIFO directly on zero delay, rejects a bad task without a walk,
// and with a delay searches for the lowest free slot; tick walks all DELAY_SLOTS
// slots; cancel walks the slots and then the fill entries of the FIFO (neither for
// task zero). Reset clears the FIFO pointers and the slot busy bits at once, so no
// clearing pass follows reset.
module delayed_message_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_task_ref,
  input  logic [15:0] in_msg_kind,
  input  logic [31:0] in_payload_handle,
  input  logic [15:0] in_delay_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_delivered,
  output logic [7:0]  out_task,
  output logic [15:0] out_kind,
  output logic [31:0] out_payload,
  output logic [5:0]  out_count,
  output logic [4:0]  out_dropped
);

  dms_pkg::dms_cmd_t  cmd;
  dms_pkg::dms_stat_t stat;

  dms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  dms_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_command),
    .in_task_ref       (in_task_ref),
    .in_msg_kind       (in_msg_kind),
    .in_payload_handle (in_payload_handle),
    .in_delay_ticks    (in_delay_ticks),
    .out_status        (out_status),
    .out_delivered     (out_delivered),
    .out_task          (out_task),
    .out_kind          (out_kind),
    .out_payload       (out_payload),
    .out_count         (out_count),
    .out_dropped       (out_dropped)
  );

endmodule

// ===== rtl/core/dms_checker.sv =====
`include "assert_macros.svh"

module dms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_delivered,
  input logic [7:0]  out_task,
  input logic [15:0] out_kind
);

  logic live_entry;

  // A live entry was popped successfully.
  assign live_entry = (out_status == dms_pkg::ST_OK) && (out_task != 8'd0) &&
                      (out_kind != 16'd0);

  // A result that is not taken stays offered.
  `DMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // One request at a time: after an accepted request the input is stalled.
  `DMS_ASSERT_NEXT(a_one_request, clk, rst_n, in_valid && !in_stall, in_stall)
  // A delivered message is a successful pop of a live entry.
  `DMS_ASSERT_IMPLY(a_live_delivery, clk, rst_n, out_valid && out_delivered, live_entry)
  // While a result is offered, no new request is taken.
  `DMS_ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_valid, in_stall)

endmodule

bind delayed_message_scheduler dms_checker u_dms_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_delivered (out_delivered),
  .out_task      (out_task),
  .out_kind      (out_kind)
);
